/* hw/rtl/text_char_scanner_core_defines.svh */
// Assertion macros shared by the scanner's checker.
`ifndef TEXT_CHAR_SCANNER_CORE_DEFINES_SVH
`define TEXT_CHAR_SCANNER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define TCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Assertion that applies only while a result is offered.
`define TCS_ASSERT_ON_OUT(label, cond, msg) \
    `TCS_ASSERT(label, i_out_valid |-> (cond), msg)

`endif

/* hw/rtl/tcs_pkg.sv */
// Shared types and constants of the text character scanner.
package tcs_pkg;

    localparam int BYTE_W      = 8;
    localparam int LINE_W      = 20;
    localparam int COL_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = 2;
    localparam int QC_W        = 3;

    // Byte codes
    localparam logic [BYTE_W-1:0] C_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] C_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] C_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] C_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] C_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] C_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] C_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] C_DEL    = 8'h7F;
    localparam logic [BYTE_W-1:0] C_LEAD   = 8'hE2;
    localparam logic [BYTE_W-1:0] C_CONT80 = 8'h80;
    localparam logic [BYTE_W-1:0] C_EN     = 8'h93;
    localparam logic [BYTE_W-1:0] C_EM     = 8'h94;
    localparam logic [BYTE_W-1:0] C_APOS   = 8'h99;
    localparam logic [BYTE_W-1:0] C_LSQ    = 8'h98;
    localparam logic [BYTE_W-1:0] C_LDQ    = 8'h9C;
    localparam logic [BYTE_W-1:0] C_RDQ    = 8'h9D;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_EN_DASH   = 3'd1,
        ERR_EM_DASH   = 3'd2,
        ERR_APOS      = 3'd3,
        ERR_QUOTE     = 3'd4,
        ERR_CONTROL   = 3'd5,
        ERR_OPEN_CMNT = 3'd6
    } t_err;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] char_out;
        logic [LINE_W-1:0] line_no;
        logic [COL_W-1:0]  column_no;
        t_err              error_code;
        logic              last;
    } t_result;

    // One or two results caused by one input byte
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_pair;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

/* hw/rtl/tcs_byte_if.sv */
// Input byte channel.
interface tcs_byte_if;
    logic                      valid;
    logic                      ready;
    logic [tcs_pkg::BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

/* hw/rtl/tcs_res_if.sv */
// Result channel.
interface tcs_res_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [tcs_pkg::BYTE_W-1:0] char_out;
    logic [tcs_pkg::LINE_W-1:0] line_no;
    logic [tcs_pkg::COL_W-1:0]  column_no;
    logic [2:0]                error_code;
    logic                      last;

    modport source (output valid, output kind, output char_out, output line_no,
                    output column_no, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input line_no,
                    input column_no, input error_code, input last, output ready);
endinterface

/* hw/rtl/tcs_front.sv */
// Front end: accepts bytes, tracks position, comments and UTF-8, builds results.
module tcs_front #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int TAB_STOP    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tcs_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_ready,
    input  tcs_pkg::t_q_status         i_status,
    output logic                       o_push,
    output tcs_pkg::t_pair             o_pair
);
    import tcs_pkg::*;

    localparam int PW  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int AW  = $clog2(TAB_STOP + 1);
    localparam int CW1 = COLUMN_BITS + 1;
    localparam int LX  = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
    localparam int CX  = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;
    localparam longint unsigned COL_MAX_L = (64'd1 << COLUMN_BITS) - 64'd1;
    localparam logic [PW-1:0] SAT_PHASE = PW'((COL_MAX_L - 64'd1) % TAB_STOP);
    localparam logic [PW-1:0] LAST_PHASE = PW'(TAB_STOP - 1);
    localparam logic [AW-1:0] TAB_AMT = AW'(TAB_STOP);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    typedef enum logic [1:0] {
        U_IDLE   = 2'd0,
        U_LEAD   = 2'd1,
        U_LEAD80 = 2'd2
    } t_utf8;

    // Comment tracking state, as seen by the comment filter
    typedef struct packed {
        logic                   in_comment;
        logic                   star_seen;
        logic                   slash_pend;
        logic [LINE_BITS-1:0]   slash_line;
        logic [COLUMN_BITS-1:0] slash_col;
    } t_cstate;

    typedef struct packed {
        t_cstate st;
        logic    emit;
    } t_feed;

    // State registers
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [PW-1:0]          r_phase, n_phase;
    t_cstate                r_cst, n_cst;
    logic                   r_cr_pend, n_cr_pend;
    logic [LINE_BITS-1:0]   r_cr_line, n_cr_line;
    logic [COLUMN_BITS-1:0] r_cr_col, n_cr_col;
    t_utf8                  r_utf8, n_utf8;
    logic [LINE_BITS-1:0]   r_lead_line, n_lead_line;
    logic [COLUMN_BITS-1:0] r_lead_col, n_lead_col;
    logic                   r_failed, n_failed;

    logic                   accept;
    logic                   pre_v, main_v, have, do_reset;
    t_result                pre, main;
    t_err                   code;
    t_feed                  fd;
    logic [CW1-1:0]         col_sum;
    logic [AW-1:0]          tab_add;

    function automatic logic [LINE_W-1:0] f_line(input logic [LINE_BITS-1:0] v);
        logic [LX-1:0] t;
        t = LX'(v);
        return t[LINE_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] f_col(input logic [COLUMN_BITS-1:0] v);
        logic [CX-1:0] t;
        t = CX'(v);
        return t[COL_W-1:0];
    endfunction

    function automatic t_result f_res(input t_kind k, input logic [BYTE_W-1:0] ch,
                                      input logic [LINE_BITS-1:0] ln,
                                      input logic [COLUMN_BITS-1:0] cl,
                                      input t_err ec);
        t_result r;
        r.kind       = k;
        r.char_out   = ch;
        r.line_no    = f_line(ln);
        r.column_no  = f_col(cl);
        r.error_code = ec;
        r.last       = 1'b0;
        return r;
    endfunction

    // Comment filter: drop comment bodies, hold a slash for one byte
    function automatic t_feed f_feed(input t_cstate s, input logic [BYTE_W-1:0] ch,
                                     input logic [LINE_BITS-1:0] ln,
                                     input logic [COLUMN_BITS-1:0] cl);
        t_feed f;
        f.st   = s;
        f.emit = 1'b0;
        if (s.in_comment) begin
            if (s.star_seen && ch == C_SLASH) begin
                f.st.in_comment = 1'b0;
                f.st.star_seen  = 1'b0;
            end else begin
                f.st.star_seen = (ch == C_STAR);
            end
        end else if (s.slash_pend && ch == C_STAR) begin
            f.st.slash_pend = 1'b0;
            f.st.in_comment = 1'b1;
            f.st.star_seen  = 1'b0;
        end else if (ch == C_SLASH) begin
            f.st.slash_pend = 1'b1;
            f.st.slash_line = ln;
            f.st.slash_col  = cl;
        end else begin
            f.emit = 1'b1;
        end
        return f;
    endfunction

    assign o_ready = !i_status.full;
    assign accept  = i_valid && o_ready;

    // Decode one byte into next state and up to two results
    always_comb begin
        n_line      = r_line;
        n_col       = r_col;
        n_phase     = r_phase;
        n_cst       = r_cst;
        n_cr_pend   = r_cr_pend;
        n_cr_line   = r_cr_line;
        n_cr_col    = r_cr_col;
        n_utf8      = r_utf8;
        n_lead_line = r_lead_line;
        n_lead_col  = r_lead_col;
        n_failed    = r_failed;
        pre_v       = 1'b0;
        main_v      = 1'b0;
        have        = 1'b0;
        do_reset    = 1'b0;
        pre         = f_res(KIND_CHAR, C_SLASH, r_cst.slash_line, r_cst.slash_col, ERR_NONE);
        main        = f_res(KIND_CHAR, i_byte, r_line, r_col, ERR_NONE);
        code        = ERR_NONE;
        fd          = f_feed(r_cst, C_LF, r_cr_line, r_cr_col);
        tab_add     = TAB_AMT - AW'(r_phase);
        col_sum     = CW1'(r_col) + CW1'(tab_add);

        if (r_failed) begin
            // drop everything up to the end of the document
            if (i_byte == C_NUL) begin
                do_reset = 1'b1;
            end
        end else if (r_cr_pend) begin
            n_cr_pend = 1'b0;
            if (i_byte == C_LF) begin
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_ONE;
                end
                n_col   = COL_ONE;
                n_phase = '0;
                n_utf8  = U_IDLE;
                n_cst   = fd.st;
                main_v  = fd.emit;
                main    = f_res(KIND_CHAR, C_LF, r_cr_line, r_cr_col, ERR_NONE);
            end else begin
                main_v   = 1'b1;
                main     = f_res(KIND_ERR, C_NUL, r_cr_line, r_cr_col, ERR_CONTROL);
                n_failed = 1'b1;
                if (i_byte == C_NUL) begin
                    do_reset = 1'b1;
                end
            end
        end else begin
            // flush a held slash that does not open a comment
            if (r_cst.slash_pend && i_byte != C_STAR) begin
                pre_v            = 1'b1;
                n_cst.slash_pend = 1'b0;
            end
            if (i_byte == C_NUL) begin
                main_v   = 1'b1;
                do_reset = 1'b1;
                if (r_cst.in_comment) begin
                    main = f_res(KIND_ERR, C_NUL, r_line, r_col, ERR_OPEN_CMNT);
                end else begin
                    main = f_res(KIND_END, C_NUL, r_line, r_col, ERR_NONE);
                end
            end else if (i_byte[7]) begin
                if (i_byte[6] && r_col != COL_MAX) begin
                    n_col   = r_col + COL_ONE;
                    n_phase = (r_phase == LAST_PHASE) ? '0 : r_phase + PW'(1);
                end
                if (r_utf8 == U_LEAD80) begin
                    unique case (i_byte) inside
                        C_EN:               code = ERR_EN_DASH;
                        C_EM:               code = ERR_EM_DASH;
                        C_APOS:             code = ERR_APOS;
                        C_LSQ, C_LDQ, C_RDQ: code = ERR_QUOTE;
                        default:            code = ERR_NONE;
                    endcase
                end
                if (code != ERR_NONE) begin
                    main_v   = 1'b1;
                    main     = f_res(KIND_ERR, C_NUL, r_lead_line, r_lead_col, code);
                    n_failed = 1'b1;
                end else begin
                    have = 1'b1;
                    if (i_byte == C_LEAD) begin
                        n_utf8      = U_LEAD;
                        n_lead_line = r_line;
                        n_lead_col  = r_col;
                    end else if (r_utf8 == U_LEAD && i_byte == C_CONT80) begin
                        n_utf8 = U_LEAD80;
                    end else begin
                        n_utf8 = U_IDLE;
                    end
                end
            end else begin
                n_utf8 = U_IDLE;
                if (i_byte < C_SPACE) begin
                    unique case (i_byte)
                        C_TAB: begin
                            have = 1'b1;
                            if (col_sum > CW1'(COL_MAX)) begin
                                n_col   = COL_MAX;
                                n_phase = SAT_PHASE;
                            end else begin
                                n_col   = col_sum[COLUMN_BITS-1:0];
                                n_phase = '0;
                            end
                        end
                        C_CR: begin
                            n_cr_pend = 1'b1;
                            n_cr_line = r_line;
                            n_cr_col  = r_col;
                        end
                        C_LF: begin
                            have = 1'b1;
                            if (r_line != LINE_MAX) begin
                                n_line = r_line + LINE_ONE;
                            end
                            n_col   = COL_ONE;
                            n_phase = '0;
                        end
                        default: begin
                            main_v   = 1'b1;
                            main     = f_res(KIND_ERR, C_NUL, r_line, r_col, ERR_CONTROL);
                            n_failed = 1'b1;
                        end
                    endcase
                end else if (i_byte == C_DEL) begin
                    main_v   = 1'b1;
                    main     = f_res(KIND_ERR, C_NUL, r_line, r_col, ERR_CONTROL);
                    n_failed = 1'b1;
                end else begin
                    have = 1'b1;
                    if (r_col != COL_MAX) begin
                        n_col   = r_col + COL_ONE;
                        n_phase = (r_phase == LAST_PHASE) ? '0 : r_phase + PW'(1);
                    end
                end
            end
            if (have) begin
                fd     = f_feed(n_cst, i_byte, r_line, r_col);
                n_cst  = fd.st;
                main_v = fd.emit;
                main   = f_res(KIND_CHAR, i_byte, r_line, r_col, ERR_NONE);
            end
        end

        // end of document: back to the start state
        if (do_reset) begin
            n_line      = LINE_ONE;
            n_col       = COL_ONE;
            n_phase     = '0;
            n_cst       = '0;
            n_cr_pend   = 1'b0;
            n_cr_line   = '0;
            n_cr_col    = '0;
            n_utf8      = U_IDLE;
            n_lead_line = '0;
            n_lead_col  = '0;
            n_failed    = 1'b0;
        end
    end

    // Pack results in order; the last one carries the last flag
    always_comb begin
        o_pair.two         = pre_v && main_v;
        o_pair.first       = pre_v ? pre : main;
        o_pair.first.last  = !(pre_v && main_v);
        o_pair.second      = main;
        o_pair.second.last = 1'b1;
        o_push             = accept && (pre_v || main_v);
    end

    // Hold scanner state, advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= LINE_ONE;
            r_col       <= COL_ONE;
            r_phase     <= '0;
            r_cst       <= '0;
            r_cr_pend   <= 1'b0;
            r_cr_line   <= '0;
            r_cr_col    <= '0;
            r_utf8      <= U_IDLE;
            r_lead_line <= '0;
            r_lead_col  <= '0;
            r_failed    <= 1'b0;
        end else if (accept) begin
            r_line      <= n_line;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_cst       <= n_cst;
            r_cr_pend   <= n_cr_pend;
            r_cr_line   <= n_cr_line;
            r_cr_col    <= n_cr_col;
            r_utf8      <= n_utf8;
            r_lead_line <= n_lead_line;
            r_lead_col  <= n_lead_col;
            r_failed    <= n_failed;
        end
    end

endmodule

/* hw/rtl/tcs_queue.sv */
// Short queue of result pairs between front and back end.
module tcs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcs_pkg::t_pair     i_pair,
    input  logic               i_pop,
    output tcs_pkg::t_pair     o_pair,
    output tcs_pkg::t_q_status o_status
);
    import tcs_pkg::*;

    t_pair            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QC_W-1:0]  r_count, n_count;

    assign o_pair          = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == QC_W'(QUEUE_DEPTH));

    // Track fill level
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QC_W'(1);
            2'b01:   n_count = r_count - QC_W'(1);
            default: n_count = r_count;
        endcase
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/tcs_back.sv */
// Back end: splits result pairs and drives the registered output.
module tcs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcs_pkg::t_pair     i_pair,
    input  tcs_pkg::t_q_status i_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output tcs_pkg::t_result   o_res
);
    import tcs_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_sec_valid;
    t_result r_sec;
    logic    load;

    assign load    = !r_out_valid || i_ready;
    assign o_pop   = load && !r_sec_valid && !i_status.empty;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Refill the output register: second result first, then the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else if (load) begin
            if (r_sec_valid) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= 1'b0;
            end else if (!i_status.empty) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= i_pair.two;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sec_valid) begin
                r_out <= r_sec;
            end else if (!i_status.empty) begin
                r_out <= i_pair.first;
                r_sec <= i_pair.second;
            end
        end
    end

endmodule

/* hw/rtl/text_char_scanner_core.sv */
// Top level of the text character scanner.
// A result is written into the pair queue, then loaded into the output register.
// Throughput: one byte per cycle while the pair queue is not full. The single
// result port moves one result per cycle while the receiver is ready, and the 4-entry
// pair queue absorbs bytes with two results (held slash plus the next one).
// Reset: synchronous, active low; clears scanner state, queue and output register.
module text_char_scanner_core #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int TAB_STOP    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tcs_byte_if.sink       i_byte,
    tcs_res_if.source      o_res
);
    import tcs_pkg::*;

    t_q_status q_status;
    t_pair     push_pair;
    t_pair     head_pair;
    logic      push;
    logic      pop;
    t_result   res;

    // Front end
    tcs_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .TAB_STOP    (TAB_STOP)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_byte.valid),
        .i_byte   (i_byte.byte_in),
        .o_ready  (i_byte.ready),
        .i_status (q_status),
        .o_push   (push),
        .o_pair   (push_pair)
    );

    // Decoupling queue
    tcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pair   (push_pair),
        .i_pop    (pop),
        .o_pair   (head_pair),
        .o_status (q_status)
    );

    // Back end
    tcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (head_pair),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_res    (res)
    );

    assign o_res.kind       = res.kind;
    assign o_res.char_out   = res.char_out;
    assign o_res.line_no    = res.line_no;
    assign o_res.column_no  = res.column_no;
    assign o_res.error_code = res.error_code;
    assign o_res.last       = res.last;

endmodule

/* hw/rtl/tcs_checker.sv */
// Port checker for the scanner and its bind to the top level.
`include "text_char_scanner_core_defines.svh"

module tcs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [1:0]                 i_kind,
    input logic [tcs_pkg::BYTE_W-1:0] i_char,
    input logic [tcs_pkg::LINE_W-1:0] i_line,
    input logic [tcs_pkg::COL_W-1:0]  i_col,
    input logic [2:0]                 i_code,
    input logic                       i_last
);
    import tcs_pkg::*;

    // Hold a stalled result
    `TCS_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_char) && $stable(i_line) && $stable(i_col) && $stable(i_code) && $stable(i_last), "stalled result changed")
    // Error code present exactly on errors
    `TCS_ASSERT_ON_OUT(a_code_kind, (i_kind == KIND_ERR) == (i_code != ERR_NONE), "error code mismatch")
    // Only characters carry a byte
    `TCS_ASSERT_ON_OUT(a_char_zero, i_kind == KIND_CHAR || i_char == C_NUL, "non-character with byte")
    // End and error close the results of their byte
    `TCS_ASSERT_ON_OUT(a_final_last, i_kind == KIND_CHAR || i_last, "end or error not last")

endmodule

bind text_char_scanner_core tcs_checker u_tcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_char      (o_res.char_out),
    .i_line      (o_res.line_no),
    .i_col       (o_res.column_no),
    .i_code      (o_res.error_code),
    .i_last      (o_res.last)
);

/* tb/text_char_scanner_core_tb.sv */
// Self-checking testbench for the text character scanner core.
`timescale 1ns / 1ps

module text_char_scanner_core_tb;
    import tcs_pkg::*;

    localparam int TAB_W = 4;
    localparam logic [LINE_W-1:0] LINE_TOP = '1;
    localparam logic [COL_W-1:0]  COL_TOP  = '1;
    localparam int RANDOM_BYTES = 600;

    // One row of the directed table; lit marks a row whose single result is typed in
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              lit;
        t_kind             kind;
        logic [BYTE_W-1:0] ch;
        logic [LINE_W-1:0] ln;
        logic [COL_W-1:0]  cl;
        t_err              code;
    } t_row;

    // What the driver hands to the monitor along with each byte
    typedef struct packed {
        logic              lit;
        t_result           want;
    } t_feed;

    localparam int DIR_ROWS = 27;
    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        '{C_NUL,    1'b1, KIND_END,  8'h00,    20'd1, 16'd1, ERR_NONE},
        '{8'h41,    1'b1, KIND_CHAR, 8'h41,    20'd1, 16'd1, ERR_NONE},
        '{C_TAB,    1'b1, KIND_CHAR, C_TAB,    20'd1, 16'd2, ERR_NONE},
        '{8'hFF,    1'b1, KIND_CHAR, 8'hFF,    20'd1, 16'd5, ERR_NONE},
        '{C_CONT80, 1'b1, KIND_CHAR, C_CONT80, 20'd1, 16'd6, ERR_NONE},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_STAR,   1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_STAR,   1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_STAR,   1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{8'h01,    1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{8'h7A,    1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_NUL,    1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_CR,     1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_LF,     1'b1, KIND_CHAR, C_LF,     20'd1, 16'd1, ERR_NONE},
        '{C_LEAD,   1'b1, KIND_CHAR, C_LEAD,   20'd2, 16'd1, ERR_NONE},
        '{C_CONT80, 1'b1, KIND_CHAR, C_CONT80, 20'd2, 16'd2, ERR_NONE},
        '{C_EM,     1'b1, KIND_ERR,  8'h00,    20'd2, 16'd1, ERR_EM_DASH},
        '{C_NUL,    1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_CR,     1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_NUL,    1'b1, KIND_ERR,  8'h00,    20'd1, 16'd1, ERR_CONTROL},
        '{C_SLASH,  1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_STAR,   1'b0, KIND_CHAR, 8'h00,    20'd0, 16'd0, ERR_NONE},
        '{C_NUL,    1'b1, KIND_ERR,  8'h00,    20'd1, 16'd3, ERR_OPEN_CMNT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcs_byte_if byte_ch ();
    tcs_res_if  res_ch ();

    text_char_scanner_core #(
        .LINE_BITS   (LINE_W),
        .COLUMN_BITS (COL_W),
        .TAB_STOP    (TAB_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scanner state mirrored by the predictor
    logic [LINE_W-1:0] pos_line;
    logic [COL_W-1:0]  pos_col;
    logic              slash_held;
    logic [LINE_W-1:0] slash_ln;
    logic [COL_W-1:0]  slash_cl;
    logic              cr_held;
    logic [LINE_W-1:0] cr_ln;
    logic [COL_W-1:0]  cr_cl;
    logic              in_cmt;
    logic              cmt_star;
    logic [1:0]        dash_stage;
    logic [LINE_W-1:0] lead_ln;
    logic [COL_W-1:0]  lead_cl;
    logic              doc_dead;

    t_result scan_out [2];
    int      scan_n;

    t_result     due_results [$];
    t_feed       cur_feed;
    logic [7:0]  byte_plan [$];
    logic        calm;

    int mismatches      = 0;
    int results_checked = 0;
    int live_bytes      = 0;
    int bytes_fed       = 0;
    int docs_fed        = 0;
    int errors_seen     = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("[%0t] mismatch on result %0d: %s", $time, results_checked, what);
        mismatches++;
    endtask

    function automatic void reset_scanner();
        pos_line   = LINE_W'(1);
        pos_col    = COL_W'(1);
        slash_held = 1'b0;
        slash_ln   = '0;
        slash_cl   = '0;
        cr_held    = 1'b0;
        cr_ln      = '0;
        cr_cl      = '0;
        in_cmt     = 1'b0;
        cmt_star   = 1'b0;
        dash_stage = 2'd0;
        lead_ln    = '0;
        lead_cl    = '0;
        doc_dead   = 1'b0;
    endfunction

    function automatic void add_result(input t_kind k, input logic [BYTE_W-1:0] ch,
                                       input logic [LINE_W-1:0] ln,
                                       input logic [COL_W-1:0] cl, input t_err code);
        t_result r;
        r.kind       = k;
        r.char_out   = ch;
        r.line_no    = ln;
        r.column_no  = cl;
        r.error_code = code;
        r.last       = 1'b0;
        scan_out[scan_n] = r;
        scan_n++;
    endfunction

    function automatic void flag_error(input t_err code, input logic [LINE_W-1:0] ln,
                                       input logic [COL_W-1:0] cl);
        add_result(KIND_ERR, 8'h00, ln, cl, code);
        doc_dead = 1'b1;
    endfunction

    // Advance the column, holding at its top value
    function automatic void advance_col(input int unsigned k);
        int unsigned v;
        v = pos_col + k;
        pos_col = (v > COL_TOP) ? COL_TOP : COL_W'(v);
    endfunction

    function automatic void next_row();
        if (pos_line != LINE_TOP)
            pos_line = pos_line + 1'b1;
        pos_col = COL_W'(1);
    endfunction

    // Drop comment bodies, hold a slash until the next byte, deliver the rest
    function automatic void strip_comment(input logic [BYTE_W-1:0] ch,
                                          input logic [LINE_W-1:0] ln,
                                          input logic [COL_W-1:0] cl);
        if (in_cmt) begin
            if (cmt_star && ch == C_SLASH) begin
                in_cmt   = 1'b0;
                cmt_star = 1'b0;
            end else begin
                cmt_star = (ch == C_STAR);
            end
        end else if (slash_held && ch == C_STAR) begin
            slash_held = 1'b0;
            in_cmt     = 1'b1;
            cmt_star   = 1'b0;
        end else if (ch == C_SLASH) begin
            slash_held = 1'b1;
            slash_ln   = ln;
            slash_cl   = cl;
        end else begin
            add_result(KIND_CHAR, ch, ln, cl, ERR_NONE);
        end
    endfunction

    function automatic void scan_body(input logic [BYTE_W-1:0] b);
        logic [LINE_W-1:0] at_ln;
        logic [COL_W-1:0]  at_cl;
        logic              deliver;
        t_err              code;
        deliver = 1'b0;
        code    = ERR_NONE;
        // Drop everything up to the end of a failed document
        if (doc_dead) begin
            if (b == C_NUL)
                reset_scanner();
            return;
        end
        // A held CR either pairs with LF or is a lone CR
        if (cr_held) begin
            cr_held = 1'b0;
            if (b == C_LF) begin
                next_row();
                dash_stage = 2'd0;
                strip_comment(C_LF, cr_ln, cr_cl);
            end else begin
                flag_error(ERR_CONTROL, cr_ln, cr_cl);
                if (b == C_NUL)
                    reset_scanner();
            end
            return;
        end
        if (slash_held && b != C_STAR) begin
            add_result(KIND_CHAR, C_SLASH, slash_ln, slash_cl, ERR_NONE);
            slash_held = 1'b0;
        end
        // End of document
        if (b == C_NUL) begin
            if (in_cmt)
                flag_error(ERR_OPEN_CMNT, pos_line, pos_col);
            else
                add_result(KIND_END, 8'h00, pos_line, pos_col, ERR_NONE);
            reset_scanner();
            return;
        end
        at_ln = pos_line;
        at_cl = pos_col;
        if (b[7]) begin
            // Only lead bytes take a column
            if (b[6])
                advance_col(1);
            if (dash_stage == 2'd2) begin
                case (b)
                    C_EN:                code = ERR_EN_DASH;
                    C_EM:                code = ERR_EM_DASH;
                    C_APOS:              code = ERR_APOS;
                    C_LSQ, C_LDQ, C_RDQ: code = ERR_QUOTE;
                    default:             code = ERR_NONE;
                endcase
            end
            if (code != ERR_NONE) begin
                flag_error(code, lead_ln, lead_cl);
                return;
            end
            if (b == C_LEAD) begin
                dash_stage = 2'd1;
                lead_ln    = at_ln;
                lead_cl    = at_cl;
            end else if (dash_stage == 2'd1 && b == C_CONT80) begin
                dash_stage = 2'd2;
            end else begin
                dash_stage = 2'd0;
            end
            deliver = 1'b1;
        end else begin
            dash_stage = 2'd0;
            if (b < C_SPACE) begin
                if (b == C_TAB) begin
                    advance_col(TAB_W - ((pos_col - 1) % TAB_W));
                    deliver = 1'b1;
                end else if (b == C_CR) begin
                    cr_held = 1'b1;
                    cr_ln   = at_ln;
                    cr_cl   = at_cl;
                end else if (b == C_LF) begin
                    next_row();
                    deliver = 1'b1;
                end else begin
                    flag_error(ERR_CONTROL, at_ln, at_cl);
                end
            end else if (b == C_DEL) begin
                flag_error(ERR_CONTROL, at_ln, at_cl);
            end else begin
                advance_col(1);
                deliver = 1'b1;
            end
        end
        if (deliver)
            strip_comment(b, at_ln, at_cl);
    endfunction

    // Predict the results of one byte into scan_out, marking the final one
    function automatic void scan_byte(input logic [BYTE_W-1:0] b);
        scan_n = 0;
        scan_body(b);
        if (scan_n > 0)
            scan_out[scan_n-1].last = 1'b1;
    endfunction

    // Check each result transfer, then predict each byte transfer
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                t_result want;
                want = due_results.pop_front();
                if (res_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", res_ch.kind, want.kind));
                if (res_ch.char_out !== want.char_out)
                    report_mismatch($sformatf("char %h, want %h",
                                              res_ch.char_out, want.char_out));
                if (res_ch.line_no !== want.line_no)
                    report_mismatch($sformatf("line %0d, want %0d",
                                              res_ch.line_no, want.line_no));
                if (res_ch.column_no !== want.column_no)
                    report_mismatch($sformatf("column %0d, want %0d",
                                              res_ch.column_no, want.column_no));
                if (res_ch.error_code !== want.error_code)
                    report_mismatch($sformatf("error code %0d, want %0d",
                                              res_ch.error_code, want.error_code));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", res_ch.last, want.last));
                if (want.kind == KIND_ERR)
                    errors_seen++;
            end
            results_checked++;
        end
        if (byte_ch.valid && byte_ch.ready) begin
            bytes_fed++;
            if (!doc_dead)
                live_bytes++;
            if (byte_ch.byte_in == C_NUL)
                docs_fed++;
            scan_byte(byte_ch.byte_in);
            if (cur_feed.lit) begin
                due_results.push_back(cur_feed.want);
            end else begin
                for (int i = 0; i < scan_n; i++)
                    due_results.push_back(scan_out[i]);
            end
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Present one byte and hold it until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input t_feed f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        cur_feed        <= f;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_plan();
        t_feed f;
        f = '0;
        while (byte_plan.size() != 0)
            send_byte(byte_plan.pop_front(), f);
    endtask

    // Append one token of document text, mostly well formed
    function automatic void plan_token();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            byte_plan.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 48) begin
            byte_plan.push_back(C_TAB);
        end else if (r < 54) begin
            byte_plan.push_back(C_LF);
        end else if (r < 60) begin
            byte_plan.push_back(C_CR);
            byte_plan.push_back(C_LF);
        end else if (r < 68) begin
            // Block comment, now and then left open
            byte_plan.push_back(C_SLASH);
            byte_plan.push_back(C_STAR);
            k = $urandom_range(0, 6);
            repeat (k) begin
                case ($urandom_range(0, 4))
                    0:       byte_plan.push_back(C_STAR);
                    1:       byte_plan.push_back(C_SLASH);
                    2:       byte_plan.push_back(C_LF);
                    default: byte_plan.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
                endcase
            end
            if ($urandom_range(0, 5) != 0) begin
                byte_plan.push_back(C_STAR);
                byte_plan.push_back(C_SLASH);
            end
        end else if (r < 74) begin
            byte_plan.push_back(C_SLASH);
            byte_plan.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 80) begin
            byte_plan.push_back(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
            byte_plan.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 86) begin
            byte_plan.push_back(C_LEAD);
            byte_plan.push_back(C_CONT80);
            case ($urandom_range(0, 6))
                0:       byte_plan.push_back(C_EN);
                1:       byte_plan.push_back(C_EM);
                2:       byte_plan.push_back(C_APOS);
                3:       byte_plan.push_back(C_LSQ);
                4:       byte_plan.push_back(C_LDQ);
                5:       byte_plan.push_back(C_RDQ);
                default: byte_plan.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
            endcase
        end else if (r < 90) begin
            byte_plan.push_back(C_LEAD);
            byte_plan.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
            byte_plan.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 93) begin
            byte_plan.push_back(BYTE_W'($urandom_range(8'h01, 8'h1F)));
        end else if (r < 95) begin
            byte_plan.push_back(C_DEL);
        end else if (r < 97) begin
            byte_plan.push_back(C_CR);
            byte_plan.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
        end else begin
            byte_plan.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    // Result side: stall at random while calm is clear
    initial begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        t_feed f;
        int    start_bytes;
        int    waited;
        calm = 1'b0;
        reset_scanner();
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= '0;
        cur_feed        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            f.lit             = DIR_TABLE[i].lit;
            f.want.kind       = DIR_TABLE[i].kind;
            f.want.char_out   = DIR_TABLE[i].ch;
            f.want.line_no    = DIR_TABLE[i].ln;
            f.want.column_no  = DIR_TABLE[i].cl;
            f.want.error_code = DIR_TABLE[i].code;
            f.want.last       = 1'b1;
            send_byte(DIR_TABLE[i].data, f);
        end

        // Run a short line of tabs and mixed text with no gaps
        calm = 1'b1;
        repeat (3) byte_plan.push_back(C_TAB);
        byte_plan.push_back(8'h61);
        byte_plan.push_back(8'hC3);
        byte_plan.push_back(8'hA9);
        byte_plan.push_back(C_TAB);
        byte_plan.push_back(C_SLASH);
        byte_plan.push_back(8'h62);
        byte_plan.push_back(C_LF);
        byte_plan.push_back(8'h63);
        byte_plan.push_back(C_NUL);
        send_plan();

        // Random documents
        start_bytes = bytes_fed;
        while (bytes_fed - start_bytes < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 20)) plan_token();
            byte_plan.push_back(C_NUL);
            send_plan();
        end
        calm = 1'b0;
        byte_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        waited = 0;
        while (due_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("Scanned %0d documents (%0d bytes, %0d live), checked %0d results, %0d errors.",
                 docs_fed, bytes_fed, live_bytes, results_checked, errors_seen);
        $display("Covered comments, CR LF, tabs, UTF-8 dashes and quotes, stalls on both sides.");
        if (mismatches == 0)
            $display("** text_char_scanner_core: PASSED **");
        else
            $display("** text_char_scanner_core: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("** text_char_scanner_core: FAILED **");
        $finish;
    end

endmodule
